// File: rtl/avtp_shc_pkg.sv
// Package for the AVTP stream header check: header and result records,
// register indexes, flag positions and the AVTP header size.
// No dependencies.
`timescale 1ns / 1ps

package avtp_shc_pkg;

    // Size of the AVTP stream data header in bytes
    localparam int HEADER_BYTES = 24;

    // Register indexes (paddr[2])
    localparam logic REG_EXPECTED_SUBTYPE      = 1'b0;
    localparam logic REG_CLOCK_RECOVERY_ENABLE = 1'b1;

    // Bit positions in packet_flags
    localparam int FLAG_LOST      = 0;
    localparam int FLAG_RESTART   = 1;
    localparam int FLAG_UNCERTAIN = 2;
    localparam int FLAG_INVALID   = 3;

    // Configuration register contents
    typedef struct packed {
        logic [7:0] expected_subtype;
        logic       clock_recovery_enable;
    } cfg_t;

    // One extracted header as received
    typedef struct packed {
        logic [7:0]  subtype;
        logic [7:0]  seq_no;
        logic        restart_bit;
        logic        uncertain;
        logic        ts_valid;
        logic [31:0] timestamp;
        logic [15:0] protocol_word;
        logic [15:0] data_length;
        logic [9:0]  frame_offset;
        logic        last_in_batch;
    } hdr_t;

    // Per-packet result fields (counters are carried separately)
    typedef struct packed {
        logic        accepted;
        logic [3:0]  packet_flags;
        logic [31:0] timestamp_out;
        logic        to_clock_recovery;
        logic [15:0] payload_length;
        logic [10:0] payload_offset;
        logic [15:0] protocol_word_out;
        logic        break_before;
        logic        flush_after;
    } result_t;

    // Running counters
    typedef struct packed {
        logic [31:0] subtype_errors;
        logic [31:0] lost_count;
        logic [31:0] restart_count;
    } counters_t;

endpackage

// File: rtl/avtp_shc_cfg.sv
// APB-style configuration registers of the AVTP stream header check.
// Depends on avtp_shc_pkg.
`timescale 1ns / 1ps

module avtp_shc_cfg
    import avtp_shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_EXPECTED_SUBTYPE:      cfg_reg.expected_subtype <= pwdata[7:0];
                REG_CLOCK_RECOVERY_ENABLE: cfg_reg.clock_recovery_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux; byte lanes below bit 2 are ignored
    always_comb
    begin
        case (paddr[2])
            REG_EXPECTED_SUBTYPE:      prdata = {24'd0, cfg_reg.expected_subtype};
            REG_CLOCK_RECOVERY_ENABLE: prdata = {31'd0, cfg_reg.clock_recovery_enable};
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/avtp_shc_in_reg.sv
// Input register of the AVTP stream header check: captures one header per
// transfer and holds it while the result register is blocked.
// Depends on avtp_shc_pkg.
`timescale 1ns / 1ps

module avtp_shc_in_reg
    import avtp_shc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  hdr_t in_hdr,
    input  logic hold,
    output logic stage_valid,
    output hdr_t stage_hdr
);

    logic stage_valid_reg;
    logic stage_valid_next;
    hdr_t stage_hdr_reg;

    // Stall only when a held header cannot move on
    assign in_stall = stage_valid_reg && hold;

    assign stage_valid_next = in_stall ? stage_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_hdr_reg <= in_hdr;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_hdr   = stage_hdr_reg;

endmodule

// File: rtl/avtp_shc_check.sv
// Header checks, stream state, counters and result register of the AVTP
// stream header check.
// Depends on avtp_shc_pkg.
`timescale 1ns / 1ps

module avtp_shc_check
    import avtp_shc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      stage_valid,
    input  hdr_t      stage_hdr,
    output logic      hold,
    output logic      out_valid,
    input  logic      out_stall,
    output result_t   result,
    output counters_t counters
);

    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   result_reg;
    result_t   result_next;

    logic      seen_any_reg;
    logic      seen_any_next;
    logic [7:0] last_sequence_reg;
    logic [7:0] last_sequence_next;
    logic      last_restart_reg;
    logic      last_restart_next;
    counters_t counters_reg;
    counters_t counters_next;

    logic       advance;
    logic       match;
    logic       lost;
    logic       restart;
    logic [7:0] expected_seq;

    assign hold    = out_valid_reg && out_stall;
    assign advance = stage_valid && !hold;

    // Checks on the staged header
    assign match        = (stage_hdr.subtype == cfg.expected_subtype);
    assign expected_seq = last_sequence_reg + 8'd1;
    assign lost         = match && seen_any_reg && (stage_hdr.seq_no != expected_seq);
    assign restart      = match && (stage_hdr.restart_bit != last_restart_reg);

    // Result fields; a rejected packet clears all but the batch marks
    always_comb
    begin
        result_next = '0;
        result_next.break_before = !match || lost || restart;
        result_next.flush_after  = stage_hdr.last_in_batch;
        if (match)
        begin
            result_next.accepted                     = 1'b1;
            result_next.packet_flags[FLAG_LOST]      = lost;
            result_next.packet_flags[FLAG_RESTART]   = restart;
            result_next.packet_flags[FLAG_UNCERTAIN] = stage_hdr.uncertain;
            result_next.packet_flags[FLAG_INVALID]   = !stage_hdr.ts_valid;
            result_next.timestamp_out     = stage_hdr.ts_valid ? stage_hdr.timestamp : 32'd0;
            result_next.to_clock_recovery = stage_hdr.ts_valid && cfg.clock_recovery_enable;
            result_next.payload_length    = stage_hdr.data_length;
            result_next.payload_offset    = {1'b0, stage_hdr.frame_offset}
                                          + 11'(HEADER_BYTES);
            result_next.protocol_word_out = stage_hdr.protocol_word;
        end
    end

    // Stream state and counters after this packet
    always_comb
    begin
        seen_any_next      = seen_any_reg;
        last_sequence_next = last_sequence_reg;
        last_restart_next  = last_restart_reg;
        counters_next      = counters_reg;
        if (advance)
        begin
            if (!match)
            begin
                counters_next.subtype_errors = counters_reg.subtype_errors + 32'd1;
            end
            else
            begin
                seen_any_next      = 1'b1;
                last_sequence_next = stage_hdr.seq_no;
                last_restart_next  = stage_hdr.restart_bit;
                if (lost)
                begin
                    counters_next.lost_count = counters_reg.lost_count + 32'd1;
                end
                if (restart)
                begin
                    counters_next.restart_count = counters_reg.restart_count + 32'd1;
                end
            end
        end
    end

    // Result register holds while the receiver stalls
    assign out_valid_next = hold ? 1'b1 : stage_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            seen_any_reg      <= 1'b0;
            last_sequence_reg <= '0;
            last_restart_reg  <= 1'b0;
            counters_reg      <= '0;
        end
        else
        begin
            out_valid_reg     <= out_valid_next;
            seen_any_reg      <= seen_any_next;
            last_sequence_reg <= last_sequence_next;
            last_restart_reg  <= last_restart_next;
            counters_reg      <= counters_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Counters change only when a new result is loaded, so they match it
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign counters  = counters_reg;

endmodule

// File: rtl/avtp_stream_header_check.sv
// AVTP stream data header check, top level.
// Channels: input headers via in_valid/in_stall, results via
// out_valid/out_stall; a transfer happens when valid is high and stall low.
// Configuration through an APB-style port: expected_subtype at 0x0,
// clock_recovery_enable at 0x4; writes complete in the access cycle.
// The result passes through the input register, then the result register.
// Throughput: one header per cycle while the receiver does not stall; all
// checks are single compares and increments between the two registers.
// The running counters are shown with every result and hold the values
// after that packet.
// Reset (rst_n low, asynchronous) clears the configuration and valid
// registers, the counters and the sequence and restart history, but not
// the header and result payload registers; no result is pending
// afterwards.
// When the receiver stalls the result holds; one more header is taken
// into the input register, then in_stall rises until the result moves.
// Depends on avtp_shc_pkg, avtp_shc_cfg, avtp_shc_in_reg, avtp_shc_check.
`timescale 1ns / 1ps

module avtp_stream_header_check
    import avtp_shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // header input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  header_subtype,
    input  logic [7:0]  header_sequence,
    input  logic        header_restart_bit,
    input  logic        header_uncertain,
    input  logic        header_ts_valid,
    input  logic [31:0] header_timestamp,
    input  logic [15:0] header_protocol_word,
    input  logic [15:0] header_data_length,
    input  logic [9:0]  frame_offset,
    input  logic        last_in_batch,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [3:0]  packet_flags,
    output logic [31:0] timestamp_out,
    output logic        to_clock_recovery,
    output logic [15:0] payload_length,
    output logic [10:0] payload_offset,
    output logic [15:0] protocol_word_out,
    output logic        break_before,
    output logic        flush_after,
    output logic [31:0] subtype_errors,
    output logic [31:0] lost_count,
    output logic [31:0] restart_count
);

    cfg_t      cfg;
    hdr_t      in_hdr;
    hdr_t      stage_hdr;
    logic      stage_valid;
    logic      hold;
    result_t   result;
    counters_t counters;

    // Gather the header fields
    assign in_hdr.subtype       = header_subtype;
    assign in_hdr.seq_no        = header_sequence;
    assign in_hdr.restart_bit   = header_restart_bit;
    assign in_hdr.uncertain     = header_uncertain;
    assign in_hdr.ts_valid      = header_ts_valid;
    assign in_hdr.timestamp     = header_timestamp;
    assign in_hdr.protocol_word = header_protocol_word;
    assign in_hdr.data_length   = header_data_length;
    assign in_hdr.frame_offset  = frame_offset;
    assign in_hdr.last_in_batch = last_in_batch;

    avtp_shc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    avtp_shc_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_hdr      (in_hdr),
        .hold        (hold),
        .stage_valid (stage_valid),
        .stage_hdr   (stage_hdr)
    );

    avtp_shc_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_hdr   (stage_hdr),
        .hold        (hold),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .counters    (counters)
    );

    // Spread the result onto the output ports
    assign accepted          = result.accepted;
    assign packet_flags      = result.packet_flags;
    assign timestamp_out     = result.timestamp_out;
    assign to_clock_recovery = result.to_clock_recovery;
    assign payload_length    = result.payload_length;
    assign payload_offset    = result.payload_offset;
    assign protocol_word_out = result.protocol_word_out;
    assign break_before      = result.break_before;
    assign flush_after       = result.flush_after;
    assign subtype_errors    = counters.subtype_errors;
    assign lost_count        = counters.lost_count;
    assign restart_count     = counters.restart_count;

endmodule

// File: verif/avtp_stream_header_check_tb.sv
// Testbench for avtp_stream_header_check: directed header table, then random phases
// with sender and receiver idling; results checked against table outcomes or a local predictor.
// Depends on avtp_shc_pkg and the avtp_stream_header_check RTL.
`timescale 1ns / 1ps

module avtp_stream_header_check_tb;
    import avtp_shc_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int NUM_PHASES   = 8;
    localparam int NUM_DIRECTED = 12;

    // packet_flags bit masks
    localparam logic [3:0] F_LOST      = 4'b1 << FLAG_LOST;
    localparam logic [3:0] F_RESTART   = 4'b1 << FLAG_RESTART;
    localparam logic [3:0] F_UNCERTAIN = 4'b1 << FLAG_UNCERTAIN;
    localparam logic [3:0] F_INVALID   = 4'b1 << FLAG_INVALID;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        result_t   res;
        counters_t cnt;
    } header_outcome_t;

    typedef struct {
        hdr_t            hdr;
        bit              literal;
        header_outcome_t outcome;
    } directed_row_t;

    // DUT signals
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  header_subtype = '0;
    logic [7:0]  header_sequence = '0;
    logic        header_restart_bit = 1'b0;
    logic        header_uncertain = 1'b0;
    logic        header_ts_valid = 1'b0;
    logic [31:0] header_timestamp = '0;
    logic [15:0] header_protocol_word = '0;
    logic [15:0] header_data_length = '0;
    logic [9:0]  frame_offset = '0;
    logic        last_in_batch = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [3:0]  packet_flags;
    logic [31:0] timestamp_out;
    logic        to_clock_recovery;
    logic [15:0] payload_length;
    logic [10:0] payload_offset;
    logic [15:0] protocol_word_out;
    logic        break_before;
    logic        flush_after;
    logic [31:0] subtype_errors;
    logic [31:0] lost_count;
    logic [31:0] restart_count;

    // Predictor copy of registers and history
    logic [7:0]  cfg_subtype = '0;
    logic        cfg_recovery_en = 1'b0;
    logic        seq_seen = 1'b0;
    logic [7:0]  prev_seq = '0;
    logic        prev_restart = 1'b0;
    logic [31:0] subtype_err_cnt = '0;
    logic [31:0] lost_cnt = '0;
    logic [31:0] restart_cnt = '0;

    header_outcome_t pending_results [$];
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_request = 1'b0;
    int hold_count = 0;

    // Directed headers; literal outcomes only where they are obvious
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // subtype mismatch straight after reset
        '{'{8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 10'h000, 1'b1}, 1'b1,
          '{'{1'b0, 4'h0, 32'h0, 1'b0, 16'h0, 11'd0, 16'h0, 1'b1, 1'b1},
            '{32'd1, 32'd0, 32'd0}}},
        // first accepted packet, field maxima, mr set against reset value
        '{'{8'hff, 8'hff, 1'b1, 1'b0, 1'b1, 32'hffffffff, 16'hffff, 16'hffff, 10'h3ff, 1'b0},
          1'b1,
          '{'{1'b1, F_RESTART, 32'hffffffff, 1'b1, 16'hffff, 11'd1047, 16'hffff, 1'b1, 1'b0},
            '{32'd1, 32'd0, 32'd1}}},
        // sequence wraps 255 -> 0, tu set, tv clear, field minima
        '{'{8'hff, 8'h00, 1'b1, 1'b1, 1'b0, 32'h12345678, 16'h0, 16'h0, 10'h000, 1'b1}, 1'b1,
          '{'{1'b1, F_UNCERTAIN | F_INVALID, 32'h0, 1'b0, 16'h0, 11'd24, 16'h0, 1'b0, 1'b1},
            '{32'd1, 32'd0, 32'd1}}},
        // gap in sequence together with mr toggle
        '{'{8'hff, 8'h05, 1'b0, 1'b0, 1'b1, 32'h0, 16'h1234, 16'h0040, 10'h010, 1'b0}, 1'b1,
          '{'{1'b1, F_LOST | F_RESTART, 32'h0, 1'b1, 16'h0040, 11'd40, 16'h1234, 1'b1, 1'b0},
            '{32'd1, 32'd1, 32'd2}}},
        // rejected packet must not touch the history
        '{'{8'hfe, 8'h06, 1'b1, 1'b1, 1'b1, 32'hffffffff, 16'hffff, 16'hffff, 10'h3ff, 1'b0},
          1'b1,
          '{'{1'b0, 4'h0, 32'h0, 1'b0, 16'h0, 11'd0, 16'h0, 1'b1, 1'b0},
            '{32'd2, 32'd1, 32'd2}}},
        // clean continuation
        '{'{8'hff, 8'h06, 1'b0, 1'b0, 1'b1, 32'h1, 16'h1, 16'h1, 10'h001, 1'b1}, 1'b1,
          '{'{1'b1, 4'h0, 32'h1, 1'b1, 16'h1, 11'd25, 16'h1, 1'b0, 1'b1},
            '{32'd2, 32'd1, 32'd2}}},
        '{'{8'h7f, 8'h07, 1'b1, 1'b0, 1'b0, 32'h0, 16'h0, 16'h0, 10'h000, 1'b1}, 1'b0, '0},
        '{'{8'hff, 8'h07, 1'b0, 1'b1, 1'b1, 32'haaaaaaaa, 16'h5555, 16'haaaa, 10'h2aa, 1'b0},
          1'b0, '0},
        '{'{8'hff, 8'h08, 1'b0, 1'b0, 1'b1, 32'h55555555, 16'haaaa, 16'h5555, 10'h155, 1'b1},
          1'b0, '0},
        // repeated and then backward sequence numbers
        '{'{8'hff, 8'h08, 1'b1, 1'b1, 1'b0, 32'h80000000, 16'h8000, 16'h8000, 10'h200, 1'b0},
          1'b0, '0},
        '{'{8'hff, 8'h07, 1'b1, 1'b0, 1'b1, 32'h7fffffff, 16'h7fff, 16'h7fff, 10'h1ff, 1'b0},
          1'b0, '0},
        '{'{8'h80, 8'h08, 1'b0, 1'b1, 1'b1, 32'h0000ffff, 16'hff00, 16'h00ff, 10'h0ff, 1'b1},
          1'b0, '0}
    };

    avtp_stream_header_check uut (.*);

    always #(CLK_HALF_NS) clk = ~clk;

    // Work out the result of one transferred header and advance the history
    function automatic header_outcome_t predict_header_check(input hdr_t h);
        header_outcome_t o;
        o = '0;
        if (h.subtype != cfg_subtype) begin
            subtype_err_cnt++;
            o.res.break_before = 1'b1;
        end else begin
            if (seq_seen && h.seq_no != 8'(prev_seq + 8'd1)) begin
                o.res.packet_flags |= F_LOST;
                o.res.break_before = 1'b1;
                lost_cnt++;
            end
            if (h.restart_bit != prev_restart) begin
                o.res.packet_flags |= F_RESTART;
                o.res.break_before = 1'b1;
                prev_restart = h.restart_bit;
                restart_cnt++;
            end
            prev_seq = h.seq_no;
            seq_seen = 1'b1;
            if (h.uncertain)
                o.res.packet_flags |= F_UNCERTAIN;
            if (!h.ts_valid)
                o.res.packet_flags |= F_INVALID;
            o.res.accepted          = 1'b1;
            o.res.timestamp_out     = h.ts_valid ? h.timestamp : 32'h0;
            o.res.to_clock_recovery = h.ts_valid & cfg_recovery_en;
            o.res.payload_length    = h.data_length;
            o.res.payload_offset    = 11'(h.frame_offset) + 11'(HEADER_BYTES);
            o.res.protocol_word_out = h.protocol_word;
        end
        o.res.flush_after = h.last_in_batch;
        o.cnt = '{subtype_err_cnt, lost_cnt, restart_cnt};
        return o;
    endfunction

    // Mostly well-formed headers, with some wrong subtypes and sequence jumps
    function automatic hdr_t random_header();
        hdr_t h;
        h.subtype       = ($urandom_range(99) < 85) ? cfg_subtype : 8'($urandom);
        h.seq_no        = ($urandom_range(99) < 85) ? 8'(prev_seq + 8'd1) : 8'($urandom);
        h.restart_bit   = ($urandom_range(99) < 90) ? prev_restart : ~prev_restart;
        h.uncertain     = 1'($urandom_range(1));
        h.ts_valid      = ($urandom_range(99) < 75);
        h.timestamp     = $urandom;
        h.protocol_word = 16'($urandom);
        h.data_length   = 16'($urandom);
        h.frame_offset  = 10'($urandom);
        h.last_in_batch = ($urandom_range(99) < 20);
        return h;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endfunction

    // Write a register over APB, then read it back
    task automatic program_register(input logic reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        compare_field("prdata", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_index)
            REG_EXPECTED_SUBTYPE:      cfg_subtype = value[7:0];
            REG_CLOCK_RECOVERY_ENABLE: cfg_recovery_en = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one header after a random gap; predict once the transfer happens
    task automatic offer_header(input hdr_t h, input bit use_literal,
                                input header_outcome_t literal);
        header_outcome_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid             <= 1'b1;
        header_subtype       <= h.subtype;
        header_sequence      <= h.seq_no;
        header_restart_bit   <= h.restart_bit;
        header_uncertain     <= h.uncertain;
        header_ts_valid      <= h.ts_valid;
        header_timestamp     <= h.timestamp;
        header_protocol_word <= h.protocol_word;
        header_data_length   <= h.data_length;
        frame_offset         <= h.frame_offset;
        last_in_batch        <= h.last_in_batch;
        do @(posedge clk); while (in_stall);
        predicted = predict_header_check(h);
        pending_results.push_back(use_literal ? literal : predicted);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Result side: check each transfer, then choose the next stall
    always @(posedge clk) begin
        header_outcome_t want;
        if (out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result transfer with nothing expected", $time);
            end else begin
                want = pending_results.pop_front();
                compare_field("accepted", 32'(want.res.accepted), 32'(accepted));
                compare_field("packet_flags", 32'(want.res.packet_flags),
                              32'(packet_flags));
                compare_field("timestamp_out", want.res.timestamp_out, timestamp_out);
                compare_field("to_clock_recovery", 32'(want.res.to_clock_recovery),
                              32'(to_clock_recovery));
                compare_field("payload_length", 32'(want.res.payload_length),
                              32'(payload_length));
                compare_field("payload_offset", 32'(want.res.payload_offset),
                              32'(payload_offset));
                compare_field("protocol_word_out", 32'(want.res.protocol_word_out),
                              32'(protocol_word_out));
                compare_field("break_before", 32'(want.res.break_before),
                              32'(break_before));
                compare_field("flush_after", 32'(want.res.flush_after), 32'(flush_after));
                compare_field("subtype_errors", want.cnt.subtype_errors, subtype_errors);
                compare_field("lost_count", want.cnt.lost_count, lost_count);
                compare_field("restart_count", want.cnt.restart_count, restart_count);
            end
        end
        // long hold-off on request, otherwise random stalls
        if (hold_request && hold_count < HOLD_CYCLES) begin
            hold_count++;
            out_stall <= 1'b1;
        end else begin
            if (!hold_request)
                hold_count = 0;
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t ns: run timed out, %0d results outstanding", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus
    initial begin
        idle_mode_e mode;
        int n_items;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        program_register(REG_EXPECTED_SUBTYPE, 32'hff);
        program_register(REG_CLOCK_RECOVERY_ENABLE, 32'h1);
        foreach (directed_rows[i])
            offer_header(directed_rows[i].hdr, directed_rows[i].literal,
                         directed_rows[i].outcome);
        wait_for_results();

        // random phases, each with its own settings and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            repeat (4) @(posedge clk);
            program_register(REG_EXPECTED_SUBTYPE,
                             (p == 0) ? 32'h0 : (p == 1) ? 32'hff : $urandom_range(255));
            program_register(REG_CLOCK_RECOVERY_ENABLE, p % 2);
            mode = idle_mode_e'(p % 4);
            send_idle_pct = (mode == IDLE_SENDER) ? 66 : (mode == IDLE_BOTH) ? 10 : 0;
            recv_stall_pct <= (mode == IDLE_RECEIVER) ? 66 : (mode == IDLE_BOTH) ? 10 : 0;
            // receiver holds off at the start of one phase so the block backs up
            hold_request <= (p == 2);
            n_items = (p < 4 || p == 7) ? 200 : 180;
            for (int k = 0; k < n_items; k++) begin
                // sender pauses half way through one phase until all results are in
                if (p == 3 && k == n_items / 2)
                    wait_for_results();
                offer_header(random_header(), 1'b0, '0);
            end
            wait_for_results();
            hold_request <= 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
